// ===== hw/rtl/rsine_pkg.sv =====
// Shared types, register codes and constants for the radial sine-ring pixel block.
// Also holds the quarter-wave sine evaluation used to build the sine ROM at elaboration.
// No dependencies.
package rsine_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_FREQ_TURNS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIAS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y   = 3'd4;

   localparam int FREQ_W   = 20;
   localparam int AMP_W    = 16;
   localparam int BIAS_W   = 16;
   localparam int CENTER_W = 10;
   localparam int BLUE_W   = 8;

   localparam logic [FREQ_W-1:0]   FREQ_RESET   = 20'd210172;
   localparam logic [AMP_W-1:0]    AMP_RESET    = 16'd32640;
   localparam logic [BIAS_W-1:0]   BIAS_RESET   = 16'd32640;
   localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd150;

   localparam int DIST_FRAC   = 8;
   localparam int PHASE_FRAC  = 16;
   localparam int SINE_MAG_W  = 15;
   localparam int SINE_FRAC   = 15;
   localparam int AMP_PROD_W  = SINE_MAG_W + AMP_W;
   localparam int SUM_W       = AMP_PROD_W + 2;
   localparam int SUM_SHIFT   = SINE_FRAC + 8;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [SINE_MAG_W-1:0] sine_mag_type;

   // sine of quarter-wave step r, Q0.15, Taylor series in Q30
   function automatic sine_mag_type quarter_sine(input logic [63:0] r, input int idx_bits);
      logic [63:0]        theta;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      theta = (r * HALF_PI_Q30) >> (idx_bits - 2);
      th2   = (theta * theta) >> 30;
      acc   = $signed(theta);
      term  = ((theta * th2) >> 30) / 64'd6;
      acc   = acc - $signed(term);
      term  = ((term * th2) >> 30) / 64'd20;
      acc   = acc + $signed(term);
      term  = ((term * th2) >> 30) / 64'd42;
      acc   = acc - $signed(term);
      term  = ((term * th2) >> 30) / 64'd72;
      acc   = acc + $signed(term);
      term  = ((term * th2) >> 30) / 64'd110;
      acc   = acc - $signed(term);
      term  = ((term * th2) >> 30) / 64'd156;
      acc   = acc + $signed(term);
      term  = ((term * th2) >> 30) / 64'd210;
      acc   = acc - $signed(term);
      if (acc < 0) begin
         acc = 64'sd0;
      end
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) begin
         acc = 64'sd32767;
      end
      return acc[SINE_MAG_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/radial_sine_pattern_pixel.sv =====
// Top level of the radial sine-ring pixel block: offset, squares, pipelined square root,
// phase multiply, sine ROM lookup, amplitude scale, bias and clamp. Uses rsine_pkg.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_pix_x, req_pix_y
//   rsp      out        rsp_valid/rsp_stall  rsp_blue
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle while req_stall is low; the depth is set by the
// square root, which resolves one result bit per stage over COORD_BITS + 9 stages.
// Reset is synchronous and clears valid bits and the CSR registers; no clearing pass.
// An output register plus a skid register part the sides; req_stall is the skid flag,
// and the whole pipeline holds only while the skid register is full.
module radial_sine_pattern_pixel
   import rsine_pkg::*;
#(
   parameter int COORD_BITS      = 10,
   parameter int SINE_INDEX_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COORD_BITS-1:0]    req_pix_x,
   input  logic [COORD_BITS-1:0]    req_pix_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [BLUE_W-1:0]        rsp_blue,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CUSE    = (COORD_BITS < CENTER_W) ? COORD_BITS : CENTER_W;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int VW      = SQ_W + 1 + 2 * DIST_FRAC;
   localparam int DW      = (VW + 1) / 2;
   localparam int TW      = 2 * DW + 1;
   localparam int PW      = DW + FREQ_W;
   localparam int AW      = SINE_INDEX_BITS - 1;
   localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);

   typedef logic [SINE_MAG_W-1:0] qtab_type [QUARTER+1];

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int r = 0; r <= QUARTER; r++) begin
         tab[r] = quarter_sine(64'(r), SINE_INDEX_BITS);
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [FREQ_W-1:0]   freq_ff;
   logic [AMP_W-1:0]    amp_ff;
   logic [BIAS_W-1:0]   bias_ff;
   logic [CENTER_W-1:0] cx_ff;
   logic [CENTER_W-1:0] cy_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         amp_ff  <= AMP_RESET;
         bias_ff <= BIAS_RESET;
         cx_ff   <= CENTER_RESET;
         cy_ff   <= CENTER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FREQ_TURNS: freq_ff <= csr_wdata[FREQ_W-1:0];
            REG_AMPLITUDE:  amp_ff  <= csr_wdata[AMP_W-1:0];
            REG_BIAS:       bias_ff <= csr_wdata[BIAS_W-1:0];
            REG_CENTER_X:   cx_ff   <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:   cy_ff   <= csr_wdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_vld_ff;
   logic rsp_valid_ff;
   logic [BLUE_W-1:0] rsp_blue_ff;
   logic [BLUE_W-1:0] skid_blue_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // offset and magnitude
   logic [COORD_BITS-1:0] cx_use;
   logic [COORD_BITS-1:0] cy_use;
   logic [COORD_BITS:0]   dx;
   logic [COORD_BITS:0]   dy;
   logic [COORD_BITS:0]   dx_neg;
   logic [COORD_BITS:0]   dy_neg;
   logic [COORD_BITS-1:0] ax_in;
   logic [COORD_BITS-1:0] ay_in;
   logic [COORD_BITS-1:0] ax_ff;
   logic [COORD_BITS-1:0] ay_ff;
   logic                  v_abs_ff;

   assign cx_use = COORD_BITS'(cx_ff[CUSE-1:0]);
   assign cy_use = COORD_BITS'(cy_ff[CUSE-1:0]);
   assign dx     = {1'b0, req_pix_x} - {1'b0, cx_use};
   assign dy     = {1'b0, req_pix_y} - {1'b0, cy_use};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign ax_in  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign ay_in  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

   // squares
   logic [SQ_W-1:0] sqx_ff;
   logic [SQ_W-1:0] sqy_ff;
   logic            v_sq_ff;

   // square root, one result bit per stage
   logic [VW-1:0] sq_rem_ff  [0:DW];
   logic [DW-1:0] sq_root_ff [0:DW];
   logic [DW:0]   sq_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_abs_ff     <= 1'b0;
         v_sq_ff      <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (en) begin
         v_abs_ff     <= req_valid;
         v_sq_ff      <= v_abs_ff;
         sq_vld_ff[0] <= v_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff         <= ax_in;
         ay_ff         <= ay_in;
         sqx_ff        <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         sqy_ff        <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         sq_rem_ff[0]  <= {({1'b0, sqx_ff} + {1'b0, sqy_ff}), (2 * DIST_FRAC)'(0)};
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < DW; k++) begin : g_sqrt
      localparam int BIT = DW - 1 - k;
      logic [TW-1:0] trial;
      logic          fits;
      logic [TW-1:0] diff;
      logic [VW-1:0] rem_in;
      logic [DW-1:0] root_in;

      assign trial   = (TW'(sq_root_ff[k]) << (BIT + 1)) | (TW'(1) << (2 * BIT));
      assign fits    = TW'(sq_rem_ff[k]) >= trial;
      assign diff    = TW'(sq_rem_ff[k]) - trial;
      assign rem_in  = fits ? diff[VW-1:0] : sq_rem_ff[k];
      assign root_in = fits ? (sq_root_ff[k] | (DW'(1) << BIT)) : sq_root_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // phase, ROM address, ROM read, amplitude, bias
   logic [PW-1:0]              phase_prod;
   logic [PHASE_FRAC-1:0]      phase_ff;
   logic                       v_ph_ff;
   logic [SINE_INDEX_BITS-1:0] sidx;
   logic [AW-1:0]              rom_addr_in;
   logic [AW-1:0]              rom_addr_ff;
   logic                       neg_addr_ff;
   logic                       v_addr_ff;
   logic [SINE_MAG_W-1:0]      rom_ff;
   logic                       neg_rom_ff;
   logic                       v_rom_ff;
   logic [AMP_PROD_W-1:0]      amp_prod_ff;
   logic                       neg_amp_ff;
   logic                       v_amp_ff;
   logic [SUM_W-1:0]           bias_term;
   logic [SUM_W-1:0]           prod_ext;
   logic [SUM_W-1:0]           sum_in;
   logic [SUM_W-1:0]           sum_ff;
   logic                       v_sum_ff;
   logic [BLUE_W-1:0]          blue_in;

   assign phase_prod  = PW'(sq_root_ff[DW]) * PW'(freq_ff);
   assign sidx        = phase_ff[PHASE_FRAC-1 -: SINE_INDEX_BITS];
   assign rom_addr_in = sidx[SINE_INDEX_BITS-2]
                        ? AW'(QUARTER) - AW'(sidx[SINE_INDEX_BITS-3:0])
                        : AW'(sidx[SINE_INDEX_BITS-3:0]);
   assign bias_term   = {2'b00, bias_ff, SINE_FRAC'(0)};
   assign prod_ext    = {2'b00, amp_prod_ff};
   assign sum_in      = neg_amp_ff ? (bias_term - prod_ext) : (bias_term + prod_ext);

   always_comb begin
      priority if (sum_ff[SUM_W-1]) begin
         blue_in = '0;
      end else if (sum_ff[SUM_W-2]) begin
         blue_in = '1;
      end else begin
         blue_in = sum_ff[SUM_SHIFT +: BLUE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ph_ff   <= 1'b0;
         v_addr_ff <= 1'b0;
         v_rom_ff  <= 1'b0;
         v_amp_ff  <= 1'b0;
         v_sum_ff  <= 1'b0;
      end else if (en) begin
         v_ph_ff   <= sq_vld_ff[DW];
         v_addr_ff <= v_ph_ff;
         v_rom_ff  <= v_addr_ff;
         v_amp_ff  <= v_rom_ff;
         v_sum_ff  <= v_amp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff    <= phase_prod[DIST_FRAC +: PHASE_FRAC];
         rom_addr_ff <= rom_addr_in;
         neg_addr_ff <= sidx[SINE_INDEX_BITS-1];
         rom_ff      <= QTAB[rom_addr_ff];
         neg_rom_ff  <= neg_addr_ff;
         amp_prod_ff <= AMP_PROD_W'(rom_ff) * AMP_PROD_W'(amp_ff);
         neg_amp_ff  <= neg_rom_ff;
         sum_ff      <= sum_in;
      end
   end

   // output register and skid register
   logic rsp_take;
   logic arrive;

   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign arrive   = en && v_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         priority if (skid_vld_ff) begin
            if (rsp_take) begin
               skid_vld_ff <= 1'b0;
            end
         end else if (arrive) begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_vld_ff) begin
         if (rsp_take) begin
            rsp_blue_ff <= skid_blue_ff;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_blue_ff <= blue_in;
         end else begin
            skid_blue_ff <= blue_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_blue  = rsp_blue_ff;

`ifndef SYNTHESIS
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !skid_vld_ff && v_sum_ff) |=> skid_vld_ff)
      else $error("result arriving at a stalled output was not held in skid");

   a_sqrt_floor: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[DW] |-> (TW'(sq_rem_ff[DW]) <= (TW'(sq_root_ff[DW]) << 1)))
      else $error("square root remainder exceeds twice the root");

   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      v_addr_ff |-> (rom_addr_ff <= AW'(QUARTER)))
      else $error("sine ROM address beyond quarter wave");
`endif

endmodule
